// ----- rtl/core/pot_pkg.sv -----
`default_nettype none
package pot_pkg;

  localparam int DATA_W  = 64;
  localparam int WIDE_W  = 2 * DATA_W;
  localparam int HALF_W  = DATA_W / 2;
  localparam int STEPS   = WIDE_W;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LPC      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESPLIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPD_EN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_EN   = 3'd6;

  // operation codes
  localparam logic FUNC_UPDATE   = 1'b0;
  localparam logic FUNC_VALIDATE = 1'b1;

  // per-transaction data that rides along the pipeline
  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] cum;
    logic              wrap_hit;
    logic              ok;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/core/pot_reduce.sv -----
`default_nettype none
module pot_reduce
  import pot_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_vld,
  input  wire side_t             in_side,
  input  wire logic [WIDE_W-1:0] in_dividend,
  input  wire logic [DATA_W-1:0] modulus,
  output logic                   out_vld,
  output side_t                  out_side,
  output logic [DATA_W-1:0]      out_rem
);

  logic [STEPS:0]    vld_r;
  side_t             side_r [STEPS+1];
  logic [DATA_W-1:0] rem_r  [STEPS+1];
  logic [WIDE_W-1:0] div_r  [STEPS+1];

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      rem_r[0]  <= '0;
      div_r[0]  <= in_dividend;
    end
  end

  // one restoring division bit per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] rem_nxt;
    logic              take;

    always_comb begin
      shifted = {rem_r[i][DATA_W-2:0], div_r[i][WIDE_W-1]};
      take    = rem_r[i][DATA_W-1] | (shifted >= modulus);
      rem_nxt = take ? (shifted - modulus) : shifted;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[i+1] <= side_r[i];
        rem_r[i+1]  <= rem_nxt;
        div_r[i+1]  <= {div_r[i][WIDE_W-2:0], 1'b0};
      end
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign out_side = side_r[STEPS];
  assign out_rem  = rem_r[STEPS];

endmodule
`default_nettype wire

// ----- rtl/core/pot_mul.sv -----
`default_nettype none
module pot_mul
  import pot_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_vld,
  input  wire side_t             in_side,
  input  wire logic [DATA_W-1:0] in_a,
  input  wire logic [DATA_W-1:0] in_b,
  output logic                   out_vld,
  output side_t                  out_side,
  output logic [WIDE_W-1:0]      out_prod
);

  logic              vld_a_r, vld_b_r;
  side_t             side_a_r, side_b_r;
  logic [DATA_W-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [WIDE_W-1:0] prod_r;
  logic [WIDE_W-1:0] sum_nxt;

  // stage a: four half-width partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      side_a_r <= in_side;
      ll_r <= in_a[HALF_W-1:0]      * in_b[HALF_W-1:0];
      lh_r <= in_a[HALF_W-1:0]      * in_b[DATA_W-1:HALF_W];
      hl_r <= in_a[DATA_W-1:HALF_W] * in_b[HALF_W-1:0];
      hh_r <= in_a[DATA_W-1:HALF_W] * in_b[DATA_W-1:HALF_W];
    end
  end

  // stage b: align and sum
  always_comb begin
    sum_nxt = {{DATA_W{1'b0}}, ll_r}
            + {{HALF_W{1'b0}}, lh_r, {HALF_W{1'b0}}}
            + {{HALF_W{1'b0}}, hl_r, {HALF_W{1'b0}}}
            + {hh_r, {DATA_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_b_r <= side_a_r;
      prod_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  assign out_vld  = vld_b_r;
  assign out_side = side_b_r;
  assign out_prod = prod_r;

endmodule
`default_nettype wire

// ----- rtl/core/proof_of_transit_modular_update_core.sv -----
`default_nettype none
// Proof-of-transit modular arithmetic, one transaction per clock. An update
// returns (cumulative + lpc*((presplit + random) + share)) mod prime; a
// validate reports a match of cumulative against random+key, wrapped or mod
// prime. The pipeline runs four exact 128-bit restoring reductions of one
// bit per stage plus a two-stage multiplier and an output register; a new
// transaction is accepted every cycle. The whole pipeline freezes when
// out_stall holds a valid result; in_stall mirrors that. The user must
// write configuration only while the pipeline is empty; the block itself
// does not enforce this.
module proof_of_transit_modular_update_core
  import pot_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  wire logic [DATA_W-1:0]    in_cumulative_in,
  input  wire logic [DATA_W-1:0]    in_random_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [DATA_W-1:0]         out_cumulative_out,
  output logic                      out_verified
);

  logic [DATA_W-1:0] prime_r, share_r, lpc_r, presplit_r, key_r;
  logic              upd_en_r, val_en_r;
  logic              adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r    <= DATA_W'(2);
      share_r    <= '0;
      lpc_r      <= '0;
      presplit_r <= '0;
      key_r      <= '0;
      upd_en_r   <= 1'b0;
      val_en_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PRIME:    prime_r    <= cfg_wdata;
        REG_SHARE:    share_r    <= cfg_wdata;
        REG_LPC:      lpc_r      <= cfg_wdata;
        REG_PRESPLIT: presplit_r <= cfg_wdata;
        REG_KEY:      key_r      <= cfg_wdata;
        REG_UPD_EN:   upd_en_r   <= cfg_wdata[0];
        REG_VAL_EN:   val_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // global pipeline advance
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // entry: first sum, validate uses random+key, update presplit+random
  side_t             side0;
  logic [DATA_W:0]   sum_key, sum_pre;
  logic [WIDE_W-1:0] div0;

  always_comb begin
    sum_key        = {1'b0, in_random_in} + {1'b0, key_r};
    sum_pre        = {1'b0, presplit_r} + {1'b0, in_random_in};
    side0.func     = in_func;
    side0.cum      = in_cumulative_in;
    side0.wrap_hit = (in_cumulative_in == sum_key[DATA_W-1:0]);
    side0.ok       = 1'b0;
    div0 = (in_func == FUNC_VALIDATE) ? {{(DATA_W-1){1'b0}}, sum_key}
                                      : {{(DATA_W-1){1'b0}}, sum_pre};
  end

  logic              v1, v2, vm, v3, v4;
  side_t             s1, s1_ok, s2, sm, s3, s4;
  logic [DATA_W-1:0] r1, r2, r3, r4;
  logic [WIDE_W-1:0] div2, prod, div4;

  pot_reduce u_red1 (
    .clk, .rst_n, .adv,
    .in_vld(in_valid), .in_side(side0), .in_dividend(div0), .modulus(prime_r),
    .out_vld(v1), .out_side(s1), .out_rem(r1)
  );

  // validate verdict settles after the first reduction
  always_comb begin
    s1_ok    = s1;
    s1_ok.ok = s1.wrap_hit | (s1.cum == r1);
    div2     = {{(DATA_W-1){1'b0}}, ({1'b0, r1} + {1'b0, share_r})};
  end

  pot_reduce u_red2 (
    .clk, .rst_n, .adv,
    .in_vld(v1), .in_side(s1_ok), .in_dividend(div2), .modulus(prime_r),
    .out_vld(v2), .out_side(s2), .out_rem(r2)
  );

  pot_mul u_mul (
    .clk, .rst_n, .adv,
    .in_vld(v2), .in_side(s2), .in_a(r2), .in_b(lpc_r),
    .out_vld(vm), .out_side(sm), .out_prod(prod)
  );

  pot_reduce u_red3 (
    .clk, .rst_n, .adv,
    .in_vld(vm), .in_side(sm), .in_dividend(prod), .modulus(prime_r),
    .out_vld(v3), .out_side(s3), .out_rem(r3)
  );

  // add the carried cumulative
  assign div4 = {{(DATA_W-1){1'b0}}, ({1'b0, s3.cum} + {1'b0, r3})};

  pot_reduce u_red4 (
    .clk, .rst_n, .adv,
    .in_vld(v3), .in_side(s3), .in_dividend(div4), .modulus(prime_r),
    .out_vld(v4), .out_side(s4), .out_rem(r4)
  );

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_cum_r;
  logic              out_ver_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cum_r <= (s4.func == FUNC_UPDATE && upd_en_r) ? r4 : '0;
      out_ver_r <= (s4.func == FUNC_VALIDATE) & val_en_r & s4.ok;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cumulative_out = out_cum_r;
  assign out_verified       = out_ver_r;

endmodule
`default_nettype wire
